// ----- rtl/tws_pkg.sv -----
`default_nettype none

package tws_pkg;

  // fixed field widths
  localparam int DELAY_BITS  = 14;
  localparam int STATUS_BITS = 2;

  // request codes
  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // result status codes
  localparam logic [STATUS_BITS-1:0] STAT_ADDED     = 2'd0;
  localparam logic [STATUS_BITS-1:0] STAT_EXPIRED   = 2'd1;
  localparam logic [STATUS_BITS-1:0] STAT_BAD_DELAY = 2'd2;
  localparam logic [STATUS_BITS-1:0] STAT_POOL_FULL = 2'd3;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_TK_SLOT,
    ST_TK_DRAIN
  } state_t;

  // slot memory strobes
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } slot_ctl_t;

  // entry memory strobes
  typedef struct packed {
    logic rd_en;
    logic link_we;
    logic tag_we;
  } entry_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/timing_wheel_scheduler.sv -----
// Hashed timing wheel.
// Input channel (in_valid/in_ready): in_func selects add or tick. An add files
// in_tag in slot (beat + in_delay_beats) mod WHEEL_SLOTS and returns one item:
// added, delay out of range or pool full, always with out_last set.
// A tick advances the beat and returns every tag filed in the new slot, oldest
// first, one item per cycle while the output register can load, with out_last on
// the final one; an empty slot gives no item at all.
// Result channel (out_valid/out_ready) is a single output register; an input
// item is taken while a result still waits there.
// An add reads the slot memory in ST_IDLE and, unless refused, writes it back in
// ST_ADD; no new item is taken until ST_ADD ends. A tick reads and clears the slot,
// then drains its chain by chained reads through the entry memory.
// When out_ready is low with a result waiting, the add write-back or the next
// drain step holds in place, with no memory write, until the output register
// frees; the slot read and clear of a tick do not wait.
// After reset the slot memory is swept to empty with in_ready low; the entry
// pool starts full.
`default_nettype none

module timing_wheel_scheduler
  import tws_pkg::*;
#(
  parameter int WHEEL_SLOTS  = 16384,
  parameter int POOL_ENTRIES = 64,
  parameter int TAG_BITS     = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_func,
  input  wire logic [DELAY_BITS-1:0]  in_delay_beats,
  input  wire logic [TAG_BITS-1:0]    in_tag,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic      [STATUS_BITS-1:0] out_status,
  output logic      [TAG_BITS-1:0]    out_tag_res,
  output logic                        out_last
);

  localparam int SLOT_W = $clog2(WHEEL_SLOTS);
  localparam int IDX_W  = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(POOL_ENTRIES + 1);
  localparam int SUM_W  = ((SLOT_W > DELAY_BITS) ? SLOT_W : DELAY_BITS) + 1;
  localparam int SW     = 1 + 2 * IDX_W;

  // state and working registers
  state_t               state_r, state_nxt;
  logic [SLOT_W-1:0]    beat_r, beat_nxt;
  logic [SLOT_W-1:0]    clr_r, clr_nxt;
  logic [CNT_W-1:0]     free_count_r, free_count_nxt;
  logic [CNT_W-1:0]     fresh_r, fresh_nxt;
  logic [IDX_W-1:0]     free_head_r, free_head_nxt;
  logic [IDX_W-1:0]     e_r, e_nxt;
  logic                 pop_r, pop_nxt;
  logic                 err_r, err_nxt;
  logic [STATUS_BITS-1:0] err_stat_r, err_stat_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [TAG_BITS-1:0]  tag_r, tag_nxt;
  logic [IDX_W-1:0]     cur_r, cur_nxt;
  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [IDX_W-1:0]     tail_r, tail_nxt;
  logic [CNT_W-1:0]     n_r, n_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_BITS-1:0] out_status_r, out_status_nxt;
  logic [TAG_BITS-1:0]  out_tag_r, out_tag_nxt;
  logic                 out_last_r, out_last_nxt;

  // memory interface
  slot_ctl_t            slot_ctl;
  logic [SLOT_W-1:0]    slot_rd_addr, slot_wr_addr;
  logic [SW-1:0]        slot_wr_data, slot_rd_data;
  entry_ctl_t           entry_ctl;
  logic [IDX_W-1:0]     ent_rd_addr, link_wr_addr, link_wr_data, tag_wr_addr;
  logic [TAG_BITS-1:0]  tag_wr_data;
  logic [IDX_W-1:0]     link_rd_data;
  logic [TAG_BITS-1:0]  tag_rd_data;

  // helpers
  logic                 accept;
  logic                 can_load;
  logic                 out_load;
  logic [SUM_W-1:0]     delay_ext, sum, sum_adj;
  logic [SLOT_W-1:0]    slot_calc, beat_inc;
  logic                 bad_delay, pool_full, fresh_avail;
  logic [IDX_W-1:0]     alloc_idx;
  logic                 slot_occ;
  logic [IDX_W-1:0]     slot_head, slot_tail;
  logic                 fin;

  tws_slot_mem #(
    .DEPTH  (WHEEL_SLOTS),
    .ADDR_W (SLOT_W),
    .DATA_W (SW)
  ) u_slot_mem (
    .clk     (clk),
    .ctl     (slot_ctl),
    .rd_addr (slot_rd_addr),
    .wr_addr (slot_wr_addr),
    .wr_data (slot_wr_data),
    .rd_data (slot_rd_data)
  );

  tws_entry_mem #(
    .DEPTH (POOL_ENTRIES),
    .IDX_W (IDX_W),
    .TAG_W (TAG_BITS)
  ) u_entry_mem (
    .clk          (clk),
    .ctl          (entry_ctl),
    .rd_addr      (ent_rd_addr),
    .link_wr_addr (link_wr_addr),
    .link_wr_data (link_wr_data),
    .tag_wr_addr  (tag_wr_addr),
    .tag_wr_data  (tag_wr_data),
    .link_rd_data (link_rd_data),
    .tag_rd_data  (tag_rd_data)
  );

  // handshake
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid & in_ready;
  assign can_load = ~out_valid_r | out_ready;

  // target slot and range check
  assign delay_ext = SUM_W'(in_delay_beats);
  assign sum       = SUM_W'(beat_r) + delay_ext;
  assign sum_adj   = (sum >= SUM_W'(WHEEL_SLOTS)) ? (sum - SUM_W'(WHEEL_SLOTS)) : sum;
  assign slot_calc = sum_adj[SLOT_W-1:0];
  assign bad_delay = (in_delay_beats == '0) || (delay_ext >= SUM_W'(WHEEL_SLOTS));
  assign pool_full = (free_count_r == '0);
  assign beat_inc  = (beat_r == SLOT_W'(WHEEL_SLOTS - 1)) ? '0 : beat_r + 1'b1;

  // entry allocation: never-used entries first, then the free list
  assign fresh_avail = (fresh_r < CNT_W'(POOL_ENTRIES));
  assign alloc_idx   = fresh_avail ? IDX_W'(fresh_r) : free_head_r;

  // slot word fields
  assign slot_occ  = slot_rd_data[SW-1];
  assign slot_head = slot_rd_data[SW-2 -: IDX_W];
  assign slot_tail = slot_rd_data[IDX_W-1:0];

  // end of the chain being drained
  assign fin = (cur_r == tail_r) || (n_r == CNT_W'(POOL_ENTRIES - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == SLOT_W'(WHEEL_SLOTS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_nxt = (in_func == FUNC_TICK) ? ST_TK_SLOT : ST_ADD;
      end
      ST_ADD: begin
        if (can_load) state_nxt = ST_IDLE;
      end
      ST_TK_SLOT: begin
        state_nxt = slot_occ ? ST_TK_DRAIN : ST_IDLE;
      end
      ST_TK_DRAIN: begin
        if (can_load && fin) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath, memory strobes and result register
  always_comb begin
    beat_nxt       = beat_r;
    clr_nxt        = clr_r;
    free_count_nxt = free_count_r;
    fresh_nxt      = fresh_r;
    free_head_nxt  = free_head_r;
    e_nxt          = e_r;
    pop_nxt        = pop_r;
    err_nxt        = err_r;
    err_stat_nxt   = err_stat_r;
    slot_nxt       = slot_r;
    tag_nxt        = tag_r;
    cur_nxt        = cur_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    n_nxt          = n_r;
    out_load       = 1'b0;
    out_status_nxt = out_status_r;
    out_tag_nxt    = out_tag_r;
    out_last_nxt   = out_last_r;
    slot_ctl       = '0;
    slot_rd_addr   = beat_inc;
    slot_wr_addr   = beat_r;
    slot_wr_data   = '0;
    entry_ctl      = '0;
    ent_rd_addr    = free_head_r;
    link_wr_addr   = slot_tail;
    link_wr_data   = e_r;
    tag_wr_addr    = e_r;
    tag_wr_data    = tag_r;

    case (state_r)
      // sweep every slot to empty
      ST_CLEAR: begin
        slot_ctl.wr_en = 1'b1;
        slot_wr_addr   = clr_r;
        slot_wr_data   = '0;
        clr_nxt        = clr_r + 1'b1;
      end

      // take an item and start its reads
      ST_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_TICK) begin
            beat_nxt       = beat_inc;
            slot_ctl.rd_en = 1'b1;
            slot_rd_addr   = beat_inc;
          end else begin
            err_nxt         = bad_delay | pool_full;
            err_stat_nxt    = bad_delay ? STAT_BAD_DELAY : STAT_POOL_FULL;
            e_nxt           = alloc_idx;
            pop_nxt         = ~fresh_avail;
            slot_nxt        = slot_calc;
            tag_nxt         = in_tag;
            slot_ctl.rd_en  = 1'b1;
            slot_rd_addr    = slot_calc;
            entry_ctl.rd_en = 1'b1;
            ent_rd_addr     = free_head_r;
          end
        end
      end

      // write back the slot and entry unless the add is refused, report
      ST_ADD: begin
        if (can_load) begin
          out_load     = 1'b1;
          out_last_nxt = 1'b1;
          if (err_r) begin
            out_status_nxt = err_stat_r;
            out_tag_nxt    = '0;
          end else begin
            out_status_nxt    = STAT_ADDED;
            out_tag_nxt       = tag_r;
            slot_ctl.wr_en    = 1'b1;
            slot_wr_addr      = slot_r;
            slot_wr_data      = {1'b1, (slot_occ ? slot_head : e_r), e_r};
            entry_ctl.tag_we  = 1'b1;
            tag_wr_addr       = e_r;
            tag_wr_data       = tag_r;
            entry_ctl.link_we = slot_occ;
            link_wr_addr      = slot_tail;
            link_wr_data      = e_r;
            free_count_nxt    = free_count_r - 1'b1;
            if (pop_r) begin
              free_head_nxt = link_rd_data;
            end else begin
              fresh_nxt = fresh_r + 1'b1;
            end
          end
        end
      end

      // empty the slot and fetch the head entry
      ST_TK_SLOT: begin
        if (slot_occ) begin
          slot_ctl.wr_en  = 1'b1;
          slot_wr_addr    = beat_r;
          slot_wr_data    = '0;
          entry_ctl.rd_en = 1'b1;
          ent_rd_addr     = slot_head;
          cur_nxt         = slot_head;
          head_nxt        = slot_head;
          tail_nxt        = slot_tail;
          n_nxt           = '0;
        end
      end

      // one expired item per cycle while the result register can load, then hand the chain to the free list
      ST_TK_DRAIN: begin
        if (can_load) begin
          out_load       = 1'b1;
          out_status_nxt = STAT_EXPIRED;
          out_tag_nxt    = tag_rd_data;
          out_last_nxt   = fin;
          if (fin) begin
            entry_ctl.link_we = 1'b1;
            link_wr_addr      = cur_r;
            link_wr_data      = free_head_r;
            free_head_nxt     = head_r;
            free_count_nxt    = free_count_r + n_r + 1'b1;
          end else begin
            entry_ctl.rd_en = 1'b1;
            ent_rd_addr     = link_rd_data;
            cur_nxt         = link_rd_data;
            n_nxt           = n_r + 1'b1;
          end
        end
      end

      default: begin
      end
    endcase

    out_valid_nxt = out_load | (out_valid_r & ~out_ready);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      beat_r       <= '0;
      free_count_r <= CNT_W'(POOL_ENTRIES);
      fresh_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      beat_r       <= beat_nxt;
      free_count_r <= free_count_nxt;
      fresh_r      <= fresh_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    free_head_r  <= free_head_nxt;
    e_r          <= e_nxt;
    pop_r        <= pop_nxt;
    err_r        <= err_nxt;
    err_stat_r   <= err_stat_nxt;
    slot_r       <= slot_nxt;
    tag_r        <= tag_nxt;
    cur_r        <= cur_nxt;
    head_r       <= head_nxt;
    tail_r       <= tail_nxt;
    n_r          <= n_nxt;
    out_status_r <= out_status_nxt;
    out_tag_r    <= out_tag_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_tag_res = out_tag_r;
  assign out_last    = out_last_r;

  // free count never above the pool size
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_count_r <= CNT_W'(POOL_ENTRIES))
    else $error("free count above pool size");

  // unused entries are all counted as free
  a_fresh_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W'(POOL_ENTRIES) - fresh_r) <= free_count_r)
    else $error("free count below never-used entries");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  // an accepted tick always moves the beat
  a_tick_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func == FUNC_TICK) |=> (beat_r != $past(beat_r)))
    else $error("tick did not advance beat");

  // a drain never runs past the pool size
  a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TK_DRAIN) |-> (n_r < CNT_W'(POOL_ENTRIES)))
    else $error("drain longer than pool");

endmodule

`default_nettype wire

// ----- rtl/tws_slot_mem.sv -----
`default_nettype none

module tws_slot_mem
  import tws_pkg::*;
#(
  parameter int DEPTH  = 16384,
  parameter int ADDR_W = 14,
  parameter int DATA_W = 13
) (
  input  wire logic              clk,
  input  wire slot_ctl_t         ctl,
  input  wire logic [ADDR_W-1:0] rd_addr,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  output logic      [DATA_W-1:0] rd_data
);

  // one word per slot: occupied flag, list head, list tail
  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tws_entry_mem.sv -----
`default_nettype none

module tws_entry_mem
  import tws_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6,
  parameter int TAG_W = 16
) (
  input  wire logic             clk,
  input  wire entry_ctl_t       ctl,
  input  wire logic [IDX_W-1:0] rd_addr,
  input  wire logic [IDX_W-1:0] link_wr_addr,
  input  wire logic [IDX_W-1:0] link_wr_data,
  input  wire logic [IDX_W-1:0] tag_wr_addr,
  input  wire logic [TAG_W-1:0] tag_wr_data,
  output logic      [IDX_W-1:0] link_rd_data,
  output logic      [TAG_W-1:0] tag_rd_data
);

  // next-entry links and stored tags
  logic [IDX_W-1:0] link_mem [DEPTH];
  logic [TAG_W-1:0] tag_mem  [DEPTH];

  // link write port
  always_ff @(posedge clk) begin
    if (ctl.link_we) begin
      link_mem[link_wr_addr] <= link_wr_data;
    end
  end

  // tag write port
  always_ff @(posedge clk) begin
    if (ctl.tag_we) begin
      tag_mem[tag_wr_addr] <= tag_wr_data;
    end
  end

  // registered read of both banks at one address
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      link_rd_data <= link_mem[rd_addr];
      tag_rd_data  <= tag_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- tb/wheel_checker.sv -----
`timescale 1ns / 100ps

module wheel_checker
  import tws_pkg::*;
#(
  parameter int WHEEL_SLOTS  = 16384,
  parameter int POOL_ENTRIES = 64,
  parameter int TAG_BITS     = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic                   in_func,
  input  logic [DELAY_BITS-1:0]  in_delay_beats,
  input  logic [TAG_BITS-1:0]    in_tag,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [STATUS_BITS-1:0] out_status,
  input  logic [TAG_BITS-1:0]    out_tag_res,
  input  logic                   out_last,
  output int                     err_count,
  output int                     outstanding
);

  localparam int SLOT_BITS = $clog2(WHEEL_SLOTS);

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [TAG_BITS-1:0]    tag;
    logic                   last;
  } wheel_res_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0] slot;
    logic [TAG_BITS-1:0]  tag;
  } armed_t;

  // own copy of the wheel: current beat and every live timer in filing order
  logic [SLOT_BITS-1:0] beat;
  armed_t               armed_timers[$];
  wheel_res_t           due_results[$];
  int                   errs;

  // an add either files the tag or is refused, always one item back
  function automatic void predict_add(logic [DELAY_BITS-1:0] dly, logic [TAG_BITS-1:0] tg);
    wheel_res_t r;
    armed_t     a;
    r.last = 1'b1;
    if (dly == 0 || int'(dly) >= WHEEL_SLOTS) begin
      r.status = STAT_BAD_DELAY;
      r.tag    = '0;
    end else if (armed_timers.size() >= POOL_ENTRIES) begin
      r.status = STAT_POOL_FULL;
      r.tag    = '0;
    end else begin
      a.slot = SLOT_BITS'((int'(beat) + int'(dly)) % WHEEL_SLOTS);
      a.tag  = tg;
      armed_timers.push_back(a);
      r.status = STAT_ADDED;
      r.tag    = tg;
    end
    due_results.push_back(r);
  endfunction

  // a tick moves the beat on and releases the new slot's timers, oldest first
  function automatic void predict_tick();
    armed_t              keep[$];
    logic [TAG_BITS-1:0] fired[$];
    wheel_res_t          r;
    beat = SLOT_BITS'((int'(beat) + 1) % WHEEL_SLOTS);
    foreach (armed_timers[i]) begin
      if (armed_timers[i].slot == beat) fired.push_back(armed_timers[i].tag);
      else keep.push_back(armed_timers[i]);
    end
    armed_timers = keep;
    foreach (fired[i]) begin
      r.status = STAT_EXPIRED;
      r.tag    = fired[i];
      r.last   = (i == fired.size() - 1);
      due_results.push_back(r);
    end
  endfunction

  // compare one accepted result with the oldest expectation
  function automatic void check_result();
    wheel_res_t e;
    if (due_results.size() == 0) begin
      errs++;
      $display("%0t: unexpected item, status %0d tag %h last %0d", $time,
               out_status, out_tag_res, out_last);
    end else begin
      e = due_results.pop_front();
      if (out_status !== e.status) begin
        errs++;
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, e.status, out_status);
      end
      if (out_tag_res !== e.tag) begin
        errs++;
        $display("%0t: tag mismatch, expected %h, actual %h", $time, e.tag, out_tag_res);
      end
      if (out_last !== e.last) begin
        errs++;
        $display("%0t: last mismatch, expected %0d, actual %0d", $time, e.last, out_last);
      end
    end
  endfunction

  // results first: a result never comes from the item taken in the same cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      beat = '0;
      armed_timers.delete();
      due_results.delete();
      errs = 0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) begin
        if (in_func == FUNC_TICK) predict_tick();
        else predict_add(in_delay_beats, in_tag);
      end
    end
    err_count   <= errs;
    outstanding <= due_results.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import tws_pkg::*;

  localparam int TAG_W       = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 600000;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic                   in_func;
  logic [DELAY_BITS-1:0]  in_delay_beats;
  logic [TAG_W-1:0]       in_tag;
  logic                   out_valid;
  logic                   out_ready;
  logic [STATUS_BITS-1:0] out_status;
  logic [TAG_W-1:0]       out_tag_res;
  logic                   out_last;

  int err_count;
  int outstanding;
  int snd_idle;
  int rcv_idle;
  int long_left;
  int cycles;
  bit hold_req;

  timing_wheel_scheduler DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_delay_beats (in_delay_beats),
    .in_tag         (in_tag),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_tag_res    (out_tag_res),
    .out_last       (out_last)
  );

  wheel_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_delay_beats (in_delay_beats),
    .in_tag         (in_tag),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_tag_res    (out_tag_res),
    .out_last       (out_last),
    .err_count      (err_count),
    .outstanding    (outstanding)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // offer one item after a random gap, then wait until in_ready is seen high and return
  task automatic send_item(input logic fn, input logic [DELAY_BITS-1:0] dly,
                           input logic [TAG_W-1:0] tg);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid       <= 1'b0;
      in_func        <= 1'($urandom);
      in_delay_beats <= DELAY_BITS'($urandom);
      in_tag         <= TAG_W'($urandom);
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= fn;
    in_delay_beats <= dly;
    in_tag         <= tg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // tick with junk operands, which the block ignores
  task automatic tick_once();
    send_item(FUNC_TICK, DELAY_BITS'($urandom), TAG_W'($urandom));
  endtask

  task automatic add_burst(input int n, input int max_dly);
    repeat (n) send_item(FUNC_ADD, DELAY_BITS'($urandom_range(1, max_dly)), TAG_W'($urandom));
  endtask

  // mixed traffic: mostly short timers and ticks, a few refusals and far timers
  task automatic run_mix(input int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 32) begin
        tick_once();
      end else if (r < 37) begin
        send_item(FUNC_ADD, '0, TAG_W'($urandom));
      end else if (r < 40 && long_left > 0) begin
        long_left--;
        send_item(FUNC_ADD, DELAY_BITS'($urandom_range(100, 16383)), TAG_W'($urandom));
      end else begin
        add_burst(1, 10);
      end
    end
  endtask

  // receiver: random back-pressure, or a long hold-off on request
  initial begin
    int k;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rcv_idle);
        @(posedge clk);
      end
    end
  end

  // watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timing_wheel_scheduler verification failed");
    $finish;
  end

  // stimulus and verdict
  initial begin
    snd_idle       = 35;
    rcv_idle       = 69;
    long_left      = 4;
    hold_req       = 1'b0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_func        <= FUNC_ADD;
    in_delay_beats <= '0;
    in_tag         <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty slot, shared slot order, bad delay, far timer, tag extremes
    tick_once();
    send_item(FUNC_ADD, 14'd1, 16'hFFFF);
    send_item(FUNC_ADD, 14'd1, 16'h0000);
    send_item(FUNC_ADD, 14'd2, 16'h1234);
    send_item(FUNC_ADD, 14'd0, 16'hBEEF);
    send_item(FUNC_ADD, 14'h3FFF, 16'hA5A5);
    tick_once();
    tick_once();
    tick_once();
    send_item(FUNC_ADD, 14'd3, 16'h5A5A);
    send_item(FUNC_ADD, 14'd3, 16'h0001);
    send_item(FUNC_ADD, 14'd1, 16'h8000);
    send_item(FUNC_ADD, 14'd0, 16'hFFFF);
    tick_once();
    tick_once();
    tick_once();
    tick_once();

    // drain short timers, then flood one slot while the receiver holds off
    repeat (12) tick_once();
    hold_req = 1'b1;
    add_burst(70, 1);
    tick_once();
    run_mix(70);

    snd_idle = 69;
    rcv_idle = 35;
    run_mix(100);

    snd_idle = 0;
    rcv_idle = 0;
    add_burst(40, 3);
    run_mix(60);
    in_valid <= 1'b0;

    // let every expected item arrive, then a little longer for stray ones
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0 && outstanding == 0) begin
      $display("timing_wheel_scheduler verification clean");
    end else begin
      $display("timing_wheel_scheduler verification failed");
    end
    $finish;
  end

endmodule
